// ===== design/papr_pkg.sv =====
// Package for the I/Q block PAPR meter: shared constants and the back-end status type.
// No dependencies; every other design file but papr_queue refers to it by scoped names.
`default_nettype none
package papr_pkg;

    // Default sizing of the block store and the converter samples
    localparam int DEF_MAX_BLOCK   = 4096;
    localparam int DEF_SAMPLE_BITS = 12;

    // Block length register
    localparam int              CFG_W     = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    // Result field
    localparam int                PAPR_W   = 14;
    localparam logic [PAPR_W-1:0] PAPR_MAX = 14'h3FFF;

    // Fixed-point layout of the ratio and of its log
    localparam int M_FRAC   = 30;
    localparam int M_W      = 31;
    localparam int LOG_FRAC = 16;

    // round(256 * 10 * log10(2) * 2^16)
    localparam int          DB_W            = 26;
    localparam logic [DB_W-1:0] DB_PER_LOG2_Q16 = 26'd50504453;

    // Status handed from the back end to the front end
    typedef struct packed {
        logic store_busy;
    } t_back_status;

endpackage
`default_nettype wire

// ===== design/papr_sample_if.sv =====
// Sample channel: valid/ready handshake carrying one signed I/Q pair.
// Depends on papr_pkg for the default sample width.
`default_nettype none
interface papr_sample_if #(
    parameter int SAMPLE_BITS = papr_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface
`default_nettype wire

// ===== design/papr_result_if.sv =====
// Result channel: valid/ready handshake carrying the PAPR figure and zero-power flag.
// Depends on papr_pkg for the result width.
`default_nettype none
interface papr_result_if;
    logic                          valid;
    logic                          ready;
    logic [papr_pkg::PAPR_W-1:0]   papr_db_q8;
    logic                          zero_power;

    modport source (output valid, output papr_db_q8, output zero_power, input ready);
    modport sink   (input valid, input papr_db_q8, input zero_power, output ready);
endinterface
`default_nettype wire

// ===== design/papr_queue.sv =====
// Two-entry job queue between the front end and the back end.
// Depends on nothing but its width parameter.
`default_nettype none
module papr_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_data [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         push_ok;
    logic         pop_ok;

    assign push_ok = i_push && (r_count != 2'd2);
    assign pop_ok  = i_pop && (r_count != 2'd0);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rd_ptr];

    // Store the request payload
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/papr_front.sv =====
// Front end: block length register, sample store, running I/Q sums and fill count.
// Depends on papr_pkg and papr_sample_if; hands closed blocks to the job queue.
`default_nettype none
module papr_front #(
    parameter int MAX_BLOCK   = papr_pkg::DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = papr_pkg::DEF_SAMPLE_BITS,
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1),
    localparam int ADDR_W = $clog2(MAX_BLOCK),
    localparam int SUM_W  = SAMPLE_BITS + CNT_W,
    localparam int JOB_W  = CNT_W + 2 * SUM_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    papr_sample_if.sink                      i_sample,
    input  wire logic                        i_cfg_we,
    input  wire logic [papr_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire papr_pkg::t_back_status      i_status,
    input  wire logic                        i_queue_valid,
    output logic                             o_push,
    output logic [JOB_W-1:0]                 o_job,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic [2*SAMPLE_BITS-1:0]         o_rd_data
);
    localparam int LEN_W = (papr_pkg::CFG_W > CNT_W) ? papr_pkg::CFG_W : CNT_W;

    logic [papr_pkg::CFG_W-1:0]  r_cfg;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [SUM_W-1:0]     r_sum_i;
    logic signed [SUM_W-1:0]     r_sum_q;
    logic [2*SAMPLE_BITS-1:0]    r_mem [MAX_BLOCK];
    logic [2*SAMPLE_BITS-1:0]    r_rd_data;

    logic [LEN_W-1:0]            cfg_ext;
    logic [LEN_W-1:0]            len_eff;
    logic [CNT_W-1:0]            cnt_next;
    logic signed [SUM_W-1:0]     n_sum_i;
    logic signed [SUM_W-1:0]     n_sum_q;
    logic                        accept;
    logic                        close;

    // Clamp the block length to [2, MAX_BLOCK]
    always_comb begin
        cfg_ext = LEN_W'(r_cfg);
        if (cfg_ext < LEN_W'(2)) begin
            len_eff = LEN_W'(2);
        end else if (cfg_ext > LEN_W'(MAX_BLOCK)) begin
            len_eff = LEN_W'(MAX_BLOCK);
        end else begin
            len_eff = cfg_ext;
        end
    end

    // Take a request only while the store is free and no job waits
    assign i_sample.ready = !i_status.store_busy && !i_queue_valid;
    assign accept         = i_sample.valid && i_sample.ready;

    assign cnt_next = r_cnt + CNT_W'(1);
    assign close    = LEN_W'(cnt_next) >= len_eff;
    assign n_sum_i  = r_sum_i + SUM_W'(i_sample.sample_i);
    assign n_sum_q  = r_sum_q + SUM_W'(i_sample.sample_q);

    assign o_push = accept && close;
    assign o_job  = {cnt_next, n_sum_i, n_sum_q};

    // Hold the block length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= papr_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Advance fill count and sums; restart them when a block closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sum_i <= '0;
            r_sum_q <= '0;
        end else if (accept) begin
            if (close) begin
                r_cnt   <= '0;
                r_sum_i <= '0;
                r_sum_q <= '0;
            end else begin
                r_cnt   <= cnt_next;
                r_sum_i <= n_sum_i;
                r_sum_q <= n_sum_q;
            end
        end
    end

    // Sample store: one write port for the front, one registered read for the back
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= {i_sample.sample_i, i_sample.sample_q};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

// ===== design/papr_back.sv =====
// Back end: block mean, deviation-power pass over the store, then ratio, log2 and dB scaling.
// Depends on papr_pkg and papr_result_if; reads the store held in the front end.
`default_nettype none
module papr_back #(
    parameter int MAX_BLOCK   = papr_pkg::DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = papr_pkg::DEF_SAMPLE_BITS,
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1),
    localparam int ADDR_W = $clog2(MAX_BLOCK),
    localparam int SUM_W  = SAMPLE_BITS + CNT_W,
    localparam int JOB_W  = CNT_W + 2 * SUM_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_job_valid,
    input  wire logic [JOB_W-1:0]         i_job,
    output logic                          o_pop,
    output papr_pkg::t_back_status        o_status,
    output logic [ADDR_W-1:0]             o_rd_addr,
    input  wire logic [2*SAMPLE_BITS-1:0] i_rd_data,
    papr_result_if.source                 o_result
);
    localparam int SB     = SAMPLE_BITS;
    localparam int P_W    = 2 * SB + 1;
    localparam int NUM_W  = P_W + CNT_W;
    localparam int E_W    = $clog2(NUM_W + 1);
    localparam int LG_W   = E_W + papr_pkg::LOG_FRAC;
    localparam int SC_W   = LG_W + papr_pkg::DB_W;
    localparam int STEP_W = ($clog2(SUM_W + 1) > 5) ? $clog2(SUM_W + 1) : 5;
    localparam int M_W    = papr_pkg::M_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAN, ST_MEANFIX, ST_PASS, ST_DRAIN, ST_CHECK, ST_NORM,
        ST_LDIV, ST_SQ_A, ST_SQ_B, ST_SCALE_A, ST_SCALE_B, ST_DONE
    } t_state;

    t_state                     r_state;
    logic [CNT_W-1:0]           r_n;
    logic                       r_neg_i;
    logic                       r_neg_q;
    logic [SUM_W-1:0]           r_qi;
    logic [SUM_W-1:0]           r_qq;
    logic [CNT_W-1:0]           r_rem_i;
    logic [CNT_W-1:0]           r_rem_q;
    logic [STEP_W-1:0]          r_step;
    logic signed [SB:0]         r_mean_i;
    logic signed [SB:0]         r_mean_q;
    logic [CNT_W-1:0]           r_k;
    logic                       r_v1;
    logic                       r_v2;
    logic [P_W-1:0]             r_p;
    logic [P_W-1:0]             r_peak;
    logic [NUM_W-1:0]           r_total;
    logic [NUM_W-1:0]           r_num;
    logic [NUM_W-1:0]           r_d;
    logic [NUM_W:0]             r_rem;
    logic [E_W-1:0]             r_e;
    logic [M_W-1:0]             r_m;
    logic [2*M_W-1:0]           r_prod;
    logic [papr_pkg::LOG_FRAC-1:0] r_frac;
    logic [SC_W-1:0]            r_scaled;
    logic [papr_pkg::PAPR_W-1:0] r_res;
    logic                       r_zero;
    logic                       r_out_valid;
    logic [papr_pkg::PAPR_W-1:0] r_out_papr;
    logic                       r_out_zero;

    logic [CNT_W-1:0]           job_n;
    logic signed [SUM_W-1:0]    job_sum_i;
    logic signed [SUM_W-1:0]    job_sum_q;
    logic [CNT_W:0]             rsh_i;
    logic [CNT_W:0]             rsh_q;
    logic                       qbit_i;
    logic                       qbit_q;
    logic signed [SB:0]         di;
    logic signed [SB:0]         dq;
    logic signed [2*SB+1:0]     sq_i;
    logic signed [2*SB+1:0]     sq_q;
    logic [NUM_W:0]             d2;
    logic [NUM_W:0]             rem2;
    logic [M_W:0]               mm;
    logic [SC_W:0]              rounded;
    logic [SC_W-32:0]           q_db;
    logic                       slot_free;

    assign {job_n, job_sum_i, job_sum_q} = i_job;

    assign o_pop               = (r_state == ST_IDLE) && i_job_valid;
    assign o_status.store_busy = r_state inside {ST_MEAN, ST_MEANFIX, ST_PASS, ST_DRAIN};
    assign o_rd_addr           = r_k[ADDR_W-1:0];

    // Restoring divide step for both means
    always_comb begin
        rsh_i  = {r_rem_i, r_qi[SUM_W-1]};
        rsh_q  = {r_rem_q, r_qq[SUM_W-1]};
        qbit_i = rsh_i >= {1'b0, r_n};
        qbit_q = rsh_q >= {1'b0, r_n};
    end

    // Deviation of the stored pair from the block mean
    always_comb begin
        di   = $signed({i_rd_data[2*SB-1], i_rd_data[2*SB-1:SB]}) - r_mean_i;
        dq   = $signed({i_rd_data[SB-1], i_rd_data[SB-1:0]}) - r_mean_q;
        sq_i = di * di;
        sq_q = dq * dq;
    end

    assign d2        = {r_d, 1'b0};
    assign rem2      = {r_rem[NUM_W-1:0], 1'b0};
    assign mm        = r_prod[2*M_W-1:papr_pkg::M_FRAC];
    assign rounded   = {1'b0, r_scaled} + (SC_W + 1)'(64'd1 << 31);
    assign q_db      = rounded[SC_W:32];
    assign slot_free = !r_out_valid || o_result.ready;

    // Power pipeline: square, then accumulate total and peak
    always_ff @(posedge i_clk) begin
        r_p <= {1'b0, sq_i[2*SB-1:0]} + {1'b0, sq_q[2*SB-1:0]};
        if (r_state == ST_MEANFIX) begin
            r_total <= '0;
            r_peak  <= '0;
        end else if (r_v2) begin
            r_total <= r_total + NUM_W'(r_p);
            if (r_p > r_peak) begin
                r_peak <= r_p;
            end
        end
    end

    // Sequencer with its working registers and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_PASS);
            r_v2 <= r_v1;
            // Load the output slot when a figure is ready, drop it once taken
            if ((r_state == ST_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_n     <= job_n;
                        r_neg_i <= job_sum_i[SUM_W-1];
                        r_neg_q <= job_sum_q[SUM_W-1];
                        r_qi    <= job_sum_i[SUM_W-1] ? (~job_sum_i + SUM_W'(1)) : job_sum_i;
                        r_qq    <= job_sum_q[SUM_W-1] ? (~job_sum_q + SUM_W'(1)) : job_sum_q;
                        r_rem_i <= '0;
                        r_rem_q <= '0;
                        r_step  <= STEP_W'(SUM_W - 1);
                        r_state <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    r_rem_i <= qbit_i ? CNT_W'(rsh_i - {1'b0, r_n}) : CNT_W'(rsh_i);
                    r_rem_q <= qbit_q ? CNT_W'(rsh_q - {1'b0, r_n}) : CNT_W'(rsh_q);
                    r_qi    <= {r_qi[SUM_W-2:0], qbit_i};
                    r_qq    <= {r_qq[SUM_W-2:0], qbit_q};
                    r_step  <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= ST_MEANFIX;
                    end
                end
                ST_MEANFIX: begin
                    r_mean_i <= r_neg_i ? (SB + 1)'(~r_qi + SUM_W'(1)) : (SB + 1)'(r_qi);
                    r_mean_q <= r_neg_q ? (SB + 1)'(~r_qq + SUM_W'(1)) : (SB + 1)'(r_qq);
                    r_k      <= '0;
                    r_state  <= ST_PASS;
                end
                ST_PASS: begin
                    r_k <= r_k + CNT_W'(1);
                    if (r_k == r_n - CNT_W'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (r_total == '0) begin
                        r_res   <= '0;
                        r_zero  <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_zero  <= 1'b0;
                        r_num   <= NUM_W'(r_peak * r_n);
                        r_d     <= r_total;
                        r_e     <= '0;
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (d2 <= {1'b0, r_num}) begin
                        r_d <= d2[NUM_W-1:0];
                        r_e <= r_e + E_W'(1);
                    end else if (r_num < r_d) begin
                        r_res   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_rem   <= {1'b0, r_num - r_d};
                        r_m     <= M_W'(64'd1 << papr_pkg::M_FRAC);
                        r_step  <= STEP_W'(papr_pkg::M_FRAC - 1);
                        r_state <= ST_LDIV;
                    end
                end
                ST_LDIV: begin
                    if (rem2 >= {1'b0, r_d}) begin
                        r_rem           <= rem2 - {1'b0, r_d};
                        r_m[r_step[4:0]] <= 1'b1;
                    end else begin
                        r_rem <= rem2;
                    end
                    if (r_step == '0) begin
                        r_step  <= STEP_W'(papr_pkg::LOG_FRAC - 1);
                        r_frac  <= '0;
                        r_state <= ST_SQ_A;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                ST_SQ_A: begin
                    r_prod  <= r_m * r_m;
                    r_state <= ST_SQ_B;
                end
                ST_SQ_B: begin
                    if (mm[M_W]) begin
                        r_m              <= mm[M_W:1];
                        r_frac[r_step[3:0]] <= 1'b1;
                    end else begin
                        r_m <= mm[M_W-1:0];
                    end
                    r_step <= r_step - STEP_W'(1);
                    r_state <= (r_step == '0) ? ST_SCALE_A : ST_SQ_A;
                end
                ST_SCALE_A: begin
                    r_scaled <= SC_W'({r_e, r_frac} * papr_pkg::DB_PER_LOG2_Q16);
                    r_state  <= ST_SCALE_B;
                end
                ST_SCALE_B: begin
                    if (q_db > (SC_W - 31)'(papr_pkg::PAPR_MAX)) begin
                        r_res <= papr_pkg::PAPR_MAX;
                    end else begin
                        r_res <= q_db[papr_pkg::PAPR_W-1:0];
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_out_papr  <= r_res;
                        r_out_zero  <= r_zero;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.papr_db_q8 = r_out_papr;
    assign o_result.zero_power = r_out_zero;
endmodule
`default_nettype wire

// ===== design/iq_block_papr_meter.sv =====
// A block of N pairs is taken one pair a cycle while the input is ready; its result follows
// a mean divide, a store pass, up to NUM_W normalise steps, 30 divide steps, squaring steps
// for the log fraction and a dB scale.
// Throughput: the store's single read port locks input from block close to pass end;
// the ratio tail overlaps loading of the next block.
// Reset: synchronous active low; sums, fill count and sequencer cleared, length set to 4096.
`default_nettype none
module iq_block_papr_meter #(
    parameter int MAX_BLOCK   = papr_pkg::DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = papr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    papr_sample_if.sink                     i_sample,
    papr_result_if.source                   o_result,
    input  wire logic                       i_cfg_we,
    input  wire logic [papr_pkg::CFG_W-1:0] i_cfg_wdata
);
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int ADDR_W = $clog2(MAX_BLOCK);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int JOB_W  = CNT_W + 2 * SUM_W;

    papr_pkg::t_back_status     status;
    logic                       push;
    logic [JOB_W-1:0]           job_in;
    logic                       job_valid;
    logic [JOB_W-1:0]           job_out;
    logic                       pop;
    logic [ADDR_W-1:0]          rd_addr;
    logic [2*SAMPLE_BITS-1:0]   rd_data;

    // Accept pairs, fill the store, close blocks
    papr_front #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_status      (status),
        .i_queue_valid (job_valid),
        .o_push        (push),
        .o_job         (job_in),
        .i_rd_addr     (rd_addr),
        .o_rd_data     (rd_data)
    );

    // Hold closed blocks for the back end
    papr_queue #(
        .W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job_out)
    );

    // Measure each block and deliver the ratio
    papr_back #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_status    (status),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_result    (o_result)
    );
endmodule
`default_nettype wire
